[rtl/tpt_pkg.sv]
// Shared constants and types for the two-level page table unit.
`timescale 1ns / 1ps
`default_nettype none
package tpt_pkg;
	localparam int ADDR_W   = 32;
	localparam int FLAGS_W  = 12;
	localparam int REQ_W    = 2;
	localparam int CFG_IDX_W = 2;
	localparam int SLOT_W   = 10;

	localparam logic [REQ_W-1:0] REQ_XLATE = 2'd0;
	localparam logic [REQ_W-1:0] REQ_MAP   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_UNMAP = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_DIR_BASE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE = 2'd1;

	localparam int BIT_PRESENT = 0;
	localparam int BIT_LARGE   = 7;

	localparam logic [ADDR_W-1:0] FRAME_MASK = 32'hFFFF_F000;
	localparam logic [ADDR_W-1:0] PDE_SMALL  = 32'h0000_0003;
	localparam logic [ADDR_W-1:0] PDE_LARGE  = 32'h0000_0083;
	localparam logic [SLOT_W-1:0] SELF_SLOT  = 10'd1023;
	localparam logic [ADDR_W-1:0] DIR_RESET  = 32'h0020_0000;
	localparam logic [ADDR_W-1:0] POOL_RESET = 32'h0040_0000;

	// Which memory a directory entry selects as its second-level table
	typedef enum logic [1:0] {
		TSEL_NONE = 2'd0,
		TSEL_DIR  = 2'd1,
		TSEL_POOL = 2'd2
	} tsel_t;
endpackage
`default_nettype wire

[rtl/tpt_if.sv]
// Handshake channel interfaces: request, response and configuration write.
`timescale 1ns / 1ps
`default_nettype none
interface tpt_req_if;
	import tpt_pkg::*;
	logic               valid;
	logic               ready;
	logic [REQ_W-1:0]   req_type;
	logic [ADDR_W-1:0]  virt_addr;
	logic [ADDR_W-1:0]  phys_addr;
	logic [FLAGS_W-1:0] page_flags;
	modport source (output valid, req_type, virt_addr, phys_addr, page_flags, input ready);
	modport sink   (input valid, req_type, virt_addr, phys_addr, page_flags, output ready);
endinterface

interface tpt_rsp_if;
	import tpt_pkg::*;
	logic              valid;
	logic              ready;
	logic              ok;
	logic [ADDR_W-1:0] result_addr;
	modport source (output valid, ok, result_addr, input ready);
	modport sink   (input valid, ok, result_addr, output ready);
endinterface

interface tpt_cfg_if;
	import tpt_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [ADDR_W-1:0]    data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/tpt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module tpt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[rtl/two_level_page_table_unit.sv]
// Top level of the two-level page table unit: sequencer, registers and memories.
`timescale 1ns / 1ps
`default_nettype none
//
// Channel   Dir   Transaction moves
// req       in    req_type, virt_addr, phys_addr, page_flags
// rsp       out   ok, result_addr
// cfg       in    index, data (directory_base, table_pool_base)
//
// Sequence: the directory read is issued in the accept cycle. Answers from the
//   directory alone (large translate, refused or failed request) go S_PDE, S_OUT;
//   a table walk (translate, unmap) goes S_PDE, S_TAB, S_OUT; a map into a present
//   table goes S_PDE, S_MAPW, S_OUT; a map that allocates an empty table adds S_DIRW
//   before S_MAPW. One shared 32-bit adder/subtractor serves allocation and table lookup.
// A map splitting a large page first fills the new table, one pool write a cycle.
// Reset: a clearing pass over all NUM_TABLES*1024 pool entries loads the directory
//   and zeroes the pool; req.ready stays low during it. cfg is always ready.
// Stalls: one transaction at a time; req.ready is low until the response
//   is taken and rises the cycle after.
module two_level_page_table_unit #(
	parameter int NUM_TABLES      = 16,
	parameter int RAM_LARGE_PAGES = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	tpt_req_if.sink  req,
	tpt_rsp_if.source rsp,
	tpt_cfg_if.sink  cfg
);
	import tpt_pkg::*;

	localparam int KW    = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
	localparam int PW    = KW + SLOT_W;
	localparam int PDEP  = NUM_TABLES * 1024;
	localparam int NW    = $clog2(NUM_TABLES + 1);
	localparam logic [PW-1:0] CLR_LAST = PW'(PDEP - 1);

	typedef enum logic [7:0] {
		S_CLR   = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_PDE   = 8'b0000_0100,
		S_TAB   = 8'b0000_1000,
		S_SPLIT = 8'b0001_0000,
		S_DIRW  = 8'b0010_0000,
		S_MAPW  = 8'b0100_0000,
		S_OUT   = 8'b1000_0000
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] dir_base_q, pool_base_q;
	logic [REQ_W-1:0]  req_q;
	logic [ADDR_W-1:0] va_q, pa_q;
	logic [FLAGS_W-1:0] fl_q;
	logic [ADDR_W-1:0] npde_q;
	logic [PW-1:0]     cnt_q;
	logic [KW-1:0]     kq_q;
	logic [NW-1:0]     nft_q;
	tsel_t             tsel_q;
	logic              ok_q;
	logic [ADDR_W-1:0] res_q;
	// Upper bits of the new table address, kept while npde_q carries the split base
	logic [9:0]        alu_y_hi_q;

	// Memory ports
	logic              dir_we, pool_we;
	logic [SLOT_W-1:0] dir_waddr, dir_raddr;
	logic [ADDR_W-1:0] dir_wdata, dir_rdata;
	logic [PW-1:0]     pool_waddr, pool_raddr;
	logic [ADDR_W-1:0] pool_wdata, pool_rdata;

	// Shared adder/subtractor
	logic [ADDR_W-1:0] alu_a, alu_b, alu_y;
	logic              alu_sub;

	logic [ADDR_W-1:0] pool_frame, dir_frame, pde, tab_ent, walk_pde;
	logic [SLOT_W-1:0] di, ti;
	logic              pool_full, k_ok;
	tsel_t             walk_sel;
	logic [KW-1:0]     walk_k;

	assign pool_frame = pool_base_q & FRAME_MASK;
	assign dir_frame  = dir_base_q & FRAME_MASK;
	assign di         = va_q[31:22];
	assign ti         = va_q[21:12];
	assign pde        = dir_rdata;
	assign pool_full  = (32'(nft_q) >= 32'(NUM_TABLES));
	assign tab_ent    = (tsel_q == TSEL_DIR) ? dir_rdata : pool_rdata;

	assign alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

	// Entry whose table gets walked: the fresh PDE in S_PDE, the updated one in S_MAPW
	assign walk_pde = (state_q == S_MAPW) ? npde_q : pde;

	always_comb begin
		alu_a   = walk_pde & FRAME_MASK;
		alu_b   = pool_frame;
		alu_sub = 1'b1;
		// Map allocation computes the new table address instead
		if (state_q == S_PDE && req_q == REQ_MAP) begin
			alu_a   = pool_frame;
			alu_b   = 32'(nft_q) << 12;
			alu_sub = 1'b0;
		end
	end

	assign k_ok   = (alu_y[31:12] < 20'(NUM_TABLES));
	assign walk_k = alu_y[12 +: KW];

	always_comb begin
		if ((walk_pde & FRAME_MASK) == dir_frame) begin
			walk_sel = TSEL_DIR;
		end else if (k_ok) begin
			walk_sel = TSEL_POOL;
		end else begin
			walk_sel = TSEL_NONE;
		end
	end

	// Memory control
	always_comb begin
		dir_we     = 1'b0;
		dir_waddr  = di;
		dir_wdata  = npde_q;
		dir_raddr  = ti;
		pool_we    = 1'b0;
		pool_waddr = {walk_k, ti};
		pool_wdata = (pa_q & FRAME_MASK) | 32'(fl_q);
		pool_raddr = {walk_k, ti};
		case (state_q)
			S_CLR: begin
				dir_waddr  = cnt_q[SLOT_W-1:0];
				dir_we     = (cnt_q[PW-1:SLOT_W] == '0);
				if (cnt_q[SLOT_W-1:0] == SELF_SLOT) begin
					dir_wdata = DIR_RESET | PDE_SMALL;
				end else if ({1'b0, cnt_q[SLOT_W-1:0]} < 11'(RAM_LARGE_PAGES)) begin
					dir_wdata = {cnt_q[SLOT_W-1:0], 22'd0} | PDE_LARGE;
				end else begin
					dir_wdata = '0;
				end
				pool_we    = 1'b1;
				pool_waddr = cnt_q;
				pool_wdata = '0;
			end
			S_IDLE: begin
				dir_raddr = req.virt_addr[31:22];
			end
			S_TAB: begin
				// Unmap clears a present entry in whichever table was walked
				if (req_q == REQ_UNMAP && tab_ent[BIT_PRESENT]) begin
					dir_we     = (tsel_q == TSEL_DIR);
					dir_waddr  = ti;
					dir_wdata  = '0;
					pool_we    = (tsel_q == TSEL_POOL);
					pool_waddr = {kq_q, ti};
					pool_wdata = '0;
				end
			end
			S_SPLIT: begin
				pool_we    = 1'b1;
				pool_waddr = {kq_q, cnt_q[SLOT_W-1:0]};
				pool_wdata = {npde_q[31:22], cnt_q[SLOT_W-1:0], 12'd0} | PDE_SMALL;
			end
			S_DIRW: begin
				dir_we = 1'b1;
			end
			S_MAPW: begin
				dir_we    = (walk_sel == TSEL_DIR);
				dir_waddr = ti;
				dir_wdata = (pa_q & FRAME_MASK) | 32'(fl_q);
				pool_we   = (walk_sel == TSEL_POOL);
			end
			default: begin
			end
		endcase
	end

	// Config writes: take any time; unknown indexes drop
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_base_q  <= DIR_RESET;
			pool_base_q <= POOL_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == CFG_DIR_BASE) begin
				dir_base_q <= cfg.data;
			end else if (cfg.index == CFG_POOL_BASE) begin
				pool_base_q <= cfg.data;
			end
		end
	end

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = (state_q == S_OUT);
	assign rsp.ok          = ok_q;
	assign rsp.result_addr = res_q;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			cnt_q   <= '0;
			nft_q   <= '0;
			tsel_q  <= TSEL_NONE;
			kq_q    <= '0;
			ok_q    <= 1'b0;
			res_q   <= '0;
		end else begin
			case (state_q)
				S_CLR: begin
					cnt_q <= cnt_q + PW'(1);
					if (cnt_q == CLR_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_PDE;
					end
				end
				S_PDE: begin
					ok_q    <= 1'b0;
					res_q   <= '0;
					state_q <= S_OUT;
					tsel_q  <= walk_sel;
					// Map targets the next pool table; walks take the looked-up one
					kq_q    <= (req_q == REQ_MAP) ? nft_q[KW-1:0] : walk_k;
					if (req_q == REQ_XLATE) begin
						if (pde[BIT_PRESENT]) begin
							if (pde[BIT_LARGE]) begin
								ok_q  <= 1'b1;
								res_q <= {pde[31:22], va_q[21:0]};
							end else if (walk_sel != TSEL_NONE) begin
								state_q <= S_TAB;
							end
						end
					end else if (req_q == REQ_UNMAP) begin
						if (pde[BIT_PRESENT] && !pde[BIT_LARGE] && walk_sel != TSEL_NONE) begin
							state_q <= S_TAB;
						end
					end else if (req_q == REQ_MAP) begin
						if (va_q[11:0] == 12'd0 && di != SELF_SLOT) begin
							if (pde[BIT_LARGE] || !pde[BIT_PRESENT]) begin
								// Allocate the next pool table; split fills it first
								if (!pool_full) begin
									// A split holds the old large base in the upper bits
									npde_q  <= pde[BIT_LARGE]
										? ({pde[31:22], alu_y[21:0]} | PDE_SMALL)
										: (alu_y | PDE_SMALL);
									nft_q   <= nft_q + NW'(1);
									cnt_q   <= '0;
									state_q <= pde[BIT_LARGE] ? S_SPLIT : S_DIRW;
								end
							end else begin
								npde_q  <= pde;
								state_q <= S_MAPW;
							end
						end
					end
				end
				S_TAB: begin
					if (tab_ent[BIT_PRESENT]) begin
						ok_q <= 1'b1;
						if (req_q == REQ_XLATE) begin
							res_q <= {tab_ent[31:12], va_q[11:0]};
						end
					end
					state_q <= S_OUT;
				end
				S_SPLIT: begin
					cnt_q <= cnt_q + PW'(1);
					if (cnt_q[SLOT_W-1:0] == SELF_SLOT) begin
						// Restore the new table address over the large base
						npde_q[31:22] <= alu_y_hi_q;
						state_q       <= S_DIRW;
					end
				end
				S_DIRW: begin
					state_q <= S_MAPW;
				end
				S_MAPW: begin
					ok_q    <= (walk_sel != TSEL_NONE);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_PDE) begin
			alu_y_hi_q <= alu_y[31:22];
		end
	end

	// Capture the request payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			req_q <= req.req_type;
			va_q  <= req.virt_addr;
			pa_q  <= req.phys_addr;
			fl_q  <= req.page_flags;
		end
	end

	tpt_ram #(.WIDTH(ADDR_W), .DEPTH(1024)) u_dir (
		.clk   (clk),
		.we    (dir_we),
		.waddr (dir_waddr),
		.wdata (dir_wdata),
		.raddr (dir_raddr),
		.rdata (dir_rdata)
	);

	tpt_ram #(.WIDTH(ADDR_W), .DEPTH(PDEP)) u_pool (
		.clk   (clk),
		.we    (pool_we),
		.waddr (pool_waddr),
		.wdata (pool_wdata),
		.raddr (pool_raddr),
		.rdata (pool_rdata)
	);

	a_nft_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(nft_q) <= 32'(NUM_TABLES))
		else $error("table allocation count beyond pool size");

	a_accept_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == S_PDE))
		else $error("accepted request did not start a directory walk");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ok) |-> (rsp.result_addr == '0))
		else $error("failed response carries a nonzero address");

	a_split_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SPLIT) |-> (nft_q != '0))
		else $error("split without an allocated table");
endmodule
`default_nettype wire
